FILE: rtl/ttoi_pkg.sv
package ttoi_pkg;

   localparam int CHAR_W  = 8;
   localparam int BASE_W  = 6;
   localparam int VALUE_W = 64;
   localparam int DIGIT_W = 6;

   // radix limits and the prefix radixes
   localparam logic [BASE_W-1:0] BASE_DETECT = 6'd0;
   localparam logic [BASE_W-1:0] BASE_MIN    = 6'd2;
   localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;

   // result status codes
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_BAD_BASE = 1'b1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      status;
   } rsp_type;

endpackage

FILE: rtl/ttoi_in_reg.sv
module ttoi_in_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ttoi_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                           take,
   output logic                           char_valid,
   output logic [ttoi_pkg::CHAR_W-1:0]    char_code
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [ttoi_pkg::CHAR_W-1:0] char_ff;
   logic                        accept;

   // full and not moving on: hold off the sender
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_code;
      end
   end

   assign char_valid = valid_ff;
   assign char_code  = char_ff;

endmodule

FILE: rtl/ttoi_step.sv
module ttoi_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [ttoi_pkg::CHAR_W-1:0]   char_code,
   input  logic [ttoi_pkg::BASE_W-1:0]   number_base,
   output logic                          emit,
   output ttoi_pkg::rsp_type             rsp_out
);

   typedef enum logic [2:0] {
      PH_SPACE  = 3'd0,
      PH_FIRST  = 3'd1,
      PH_ZERO   = 3'd2,
      PH_DIGITS = 3'd3
   } phase_type;

   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_X = 8'h58;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_X = 8'h78;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] LETTER_OFS = 8'd10;

   phase_type                         phase_ff, phase_in;
   logic [ttoi_pkg::VALUE_W-1:0]      acc_ff, acc_in;
   logic                              neg_ff, neg_in;
   logic [ttoi_pkg::BASE_W-1:0]       base_ff, base_in;

   logic [7:0]                        dig_raw;
   logic [ttoi_pkg::DIGIT_W-1:0]      dig;
   logic                              is_dig;
   logic                              is_blank;
   logic                              base_bad;
   logic                              do_first;
   logic                              do_take;
   logic                              do_finish;
   logic [ttoi_pkg::VALUE_W-1:0]      prod;

   // character class and digit value
   always_comb begin
      dig_raw = 8'd0;
      is_dig  = 1'b0;
      if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
         dig_raw = char_code - CH_ZERO;
         is_dig  = 1'b1;
      end else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
         dig_raw = char_code - CH_LOWER_A + LETTER_OFS;
         is_dig  = 1'b1;
      end else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z) begin
         dig_raw = char_code - CH_UPPER_A + LETTER_OFS;
         is_dig  = 1'b1;
      end
      dig = dig_raw[ttoi_pkg::DIGIT_W-1:0];
   end

   assign is_blank = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
   assign base_bad = (number_base == 6'd1) || (number_base > ttoi_pkg::BASE_MAX);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      do_first  = 1'b0;
      do_take   = 1'b0;
      do_finish = 1'b0;
      emit      = 1'b0;
      rsp_out   = '0;
      prod      = '0;

      unique case (phase_ff)
         PH_SPACE: begin
            if (base_bad) begin
               emit           = 1'b1;
               rsp_out.status = ttoi_pkg::STATUS_BAD_BASE;
               phase_in       = PH_SPACE;
               acc_in         = '0;
               neg_in         = 1'b0;
               base_in        = '0;
            end else if (!is_blank) begin
               base_in  = number_base;
               phase_in = PH_FIRST;
               if (char_code == CH_MINUS) begin
                  neg_in = 1'b1;
               end else if (char_code != CH_PLUS) begin
                  do_first = 1'b1;
               end
            end
         end
         PH_FIRST: begin
            do_first = 1'b1;
         end
         PH_ZERO: begin
            if (char_code == CH_LOWER_X || char_code == CH_UPPER_X) begin
               base_in  = ttoi_pkg::BASE_HEX;
               phase_in = PH_DIGITS;
            end else begin
               if (base_ff == ttoi_pkg::BASE_DETECT) begin
                  base_in = ttoi_pkg::BASE_OCT;
               end
               do_take = 1'b1;
            end
         end
         PH_DIGITS: begin
            if (base_ff >= ttoi_pkg::BASE_MIN && base_ff <= ttoi_pkg::BASE_MAX) begin
               do_take = 1'b1;
            end else begin
               do_finish = 1'b1;
            end
         end
         default: begin
            do_finish = 1'b1;
         end
      endcase

      // first character after whitespace and sign: zero prefix or a digit
      if (do_first) begin
         if ((base_in == ttoi_pkg::BASE_DETECT || base_in == ttoi_pkg::BASE_HEX)
             && char_code == CH_ZERO) begin
            acc_in   = '0;
            phase_in = PH_ZERO;
         end else begin
            if (base_in == ttoi_pkg::BASE_DETECT) begin
               base_in = ttoi_pkg::BASE_DEC;
            end
            do_take = 1'b1;
         end
      end

      // multiply-add by the radix, or end of number
      if (do_take) begin
         prod = acc_ff * ttoi_pkg::VALUE_W'(base_in);
         if (is_dig && (dig < base_in)) begin
            acc_in   = prod + ttoi_pkg::VALUE_W'(dig);
            phase_in = PH_DIGITS;
         end else begin
            do_finish = 1'b1;
         end
      end

      if (do_finish) begin
         emit           = 1'b1;
         rsp_out.value  = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
         rsp_out.status = ttoi_pkg::STATUS_OK;
         phase_in       = PH_SPACE;
         acc_in         = '0;
         neg_in         = 1'b0;
         base_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SPACE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         base_ff  <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         base_ff  <= base_in;
      end
   end

`ifndef SYNTHESIS
   a_restart_after_result : assert property (@(posedge clock) disable iff (reset)
      take && emit |=> phase_ff == PH_SPACE && acc_ff == '0 && !neg_ff)
      else $error("parser not back at start after a result");

   a_digit_radix_valid : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DIGITS |-> base_ff >= ttoi_pkg::BASE_MIN && base_ff <= ttoi_pkg::BASE_MAX)
      else $error("digit phase with no usable radix");

   a_zero_prefix_clear : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ZERO |-> acc_ff == '0)
      else $error("accumulator not clear after zero prefix");

   a_bad_base_zero : assert property (@(posedge clock) disable iff (reset)
      emit && rsp_out.status == ttoi_pkg::STATUS_BAD_BASE |-> rsp_out.value == '0)
      else $error("invalid base result carries a value");
`endif

endmodule

FILE: rtl/ttoi_out_reg.sv
module ttoi_out_reg (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  ttoi_pkg::rsp_type                    rsp_in,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic signed [ttoi_pkg::VALUE_W-1:0]  rsp_parsed_value,
   output logic                                 rsp_status
);

   logic              valid_ff;
   logic              valid_in;
   ttoi_pkg::rsp_type data_ff;

   // a new result replaces the held one only once that one is taken
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_parsed_value = data_ff.value;
   assign rsp_status       = data_ff.status;

endmodule

FILE: rtl/text_to_integer_parser.sv
// a character transfer lands in the input register; the parse stage parses it from there
//   and, for the ending character of a number, loads the result register
// throughput: one character per cycle unless rsp_stall holds a result; combinational radix multiply-add
// reset (synchronous, active high): parser at start, radix register 0, both channels empty
module text_to_integer_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   // character input
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ttoi_pkg::CHAR_W-1:0]          req_char_code,
   // result output
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ttoi_pkg::VALUE_W-1:0]  rsp_parsed_value,
   output logic                                 rsp_status,
   // radix register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttoi_pkg::BASE_W-1:0]          csr_number_base
);

   logic [ttoi_pkg::BASE_W-1:0] number_base_ff;
   logic                        char_valid;
   logic [ttoi_pkg::CHAR_W-1:0] char_code;
   logic                        take;
   logic                        emit;
   ttoi_pkg::rsp_type           step_rsp;

   // radix register, always writable; 0 selects prefix detection
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= ttoi_pkg::BASE_DETECT;
      end else if (csr_valid && csr_ready) begin
         number_base_ff <= csr_number_base;
      end
   end

   // input register: holds one character until the parse stage takes it
   ttoi_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .take          (take),
      .char_valid    (char_valid),
      .char_code     (char_code)
   );

   // the parse stage moves whenever it holds a character and the result register is empty or being drained
   assign take = char_valid && (!rsp_valid || !rsp_stall);

   // parse state and the per-character step
   ttoi_step u_step (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (char_code),
      .number_base (number_base_ff),
      .emit        (emit),
      .rsp_out     (step_rsp)
   );

   // result register: parts the result transfer from the parse stage
   ttoi_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (take && emit),
      .rsp_in           (step_rsp),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_status       (rsp_status)
   );

endmodule
